// File: rtl/price_ladder_best_tracker_macros.svh
// Assertion macros shared by the price ladder RTL.
// Included by the top level; each macro expands to one concurrent assertion.
`ifndef PRICE_LADDER_BEST_TRACKER_MACROS_SVH
`define PRICE_LADDER_BEST_TRACKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLB_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLB_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/plb_pkg.sv
// Shared types and constants of the price ladder best tracker.
// No dependencies; used by the interfaces and by every module but plb_ram.
package plb_pkg;

  localparam int PRICE_W    = 32;
  localparam int ORDER_W    = 32;
  localparam int QTY_W      = 48;
  localparam int CNT_W      = 16;
  localparam int ENTRY_W    = QTY_W + CNT_W;
  localparam int WORD_W     = 32;
  localparam int BIT_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [QTY_W-1:0] QTY_MAX = {QTY_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_BASE_PRICE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOOK_SIDE  = 2'd1;

  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

endpackage

// File: rtl/plb_req_if.sv
// Command channel of the price ladder: valid, ready and one command item.
// Depends on plb_pkg for field widths.
interface plb_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  cmd;
  logic [plb_pkg::PRICE_W-1:0] price;
  logic [plb_pkg::ORDER_W-1:0] qty;

  modport source (output valid, cmd, price, qty, input ready);
  modport sink (input valid, cmd, price, qty, output ready);
endinterface

// File: rtl/plb_rsp_if.sv
// Result channel of the price ladder: valid, ready and one result item.
// Depends on plb_pkg for field widths.
interface plb_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [plb_pkg::QTY_W-1:0]   level_qty;
  logic [plb_pkg::CNT_W-1:0]   level_orders;
  logic                        best_valid;
  logic [plb_pkg::PRICE_W-1:0] top_price;
  logic [plb_pkg::QTY_W-1:0]   best_qty;

  modport source (output valid, status, level_qty, level_orders, best_valid, top_price,
                  best_qty, input ready);
  modport sink (input valid, status, level_qty, level_orders, best_valid, top_price,
                best_qty, output ready);
endinterface

// File: rtl/plb_ram.sv
// Single-port synchronous RAM with registered read data.
// No dependencies; holds the level entries and the occupancy words.
module plb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/plb_prio.sv
// Priority encoder over one occupancy word, lowest or highest set bit first.
// Depends on plb_pkg for the word and index widths.
module plb_prio (
  input  logic [plb_pkg::WORD_W-1:0] word,
  input  logic                       low_first,
  output logic                       found,
  output logic [plb_pkg::BIT_W-1:0]  idx
);

  always_comb begin
    found = |word;
    idx   = '0;
    if (low_first) begin
      for (int i = plb_pkg::WORD_W - 1; i >= 0; i--) begin
        if (word[i]) idx = plb_pkg::BIT_W'(i);
      end
    end else begin
      for (int i = 0; i < plb_pkg::WORD_W; i++) begin
        if (word[i]) idx = plb_pkg::BIT_W'(i);
      end
    end
  end

endmodule

// File: rtl/price_ladder_best_tracker.sv
// Top level of the price ladder best tracker: control sequencer and memories.
// Depends on plb_pkg, plb_req_if, plb_rsp_if, plb_ram, plb_prio and the macro header.
//
// One side of an order book over LEVELS price levels starting at base_price.
// After reset the block clears its level and occupancy memories before it takes
// the first command; configuration writes are taken throughout. A command then
// passes a read step and a modify step, while the level entry and its occupancy
// word are read, modified and written back through single-port memories, and
// then a result step that waits until the output is free. When the best level
// empties, the occupancy memory is scanned one 32-level word per cycle from the
// best end, and the new best total is then fetched in a fetch and a wait step.
// The next command is accepted while a result still waits on the output.
`include "price_ladder_best_tracker_macros.svh"

module price_ladder_best_tracker #(
  parameter int LEVELS = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [plb_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [plb_pkg::CFG_DATA_W-1:0] cfg_data,
  plb_req_if.sink                        req,
  plb_rsp_if.source                      rsp
);

  localparam int SW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int WORDS = (LEVELS + plb_pkg::WORD_W - 1) / plb_pkg::WORD_W;
  localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int NW    = $clog2(WORDS + 1);
  localparam int SXW   = SW + plb_pkg::BIT_W;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_READ   = 8'b0000_0100,
    S_MODIFY = 8'b0000_1000,
    S_SEARCH = 8'b0001_0000,
    S_FETCH  = 8'b0010_0000,
    S_FETCHW = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_t;

  state_t state;

  logic [plb_pkg::PRICE_W-1:0] base_price;
  logic                        book_side;

  logic [SW-1:0]               clr_cnt;
  plb_pkg::cmd_t               item_cmd;
  logic [plb_pkg::ORDER_W-1:0] item_qty;
  logic [SW-1:0]               slot;
  logic                        in_range;

  logic [SW-1:0]               best_slot;
  logic                        best_present;
  logic [plb_pkg::QTY_W-1:0]   best_total;

  logic [1:0]                  res_status;
  logic [plb_pkg::QTY_W-1:0]   res_lq;
  logic [plb_pkg::CNT_W-1:0]   res_lo;

  logic [WW-1:0]               scan_addr;
  logic [NW-1:0]               scan_n;
  logic                        pend;
  logic [WW-1:0]               pend_addr;

  logic [plb_pkg::PRICE_W-1:0] off;
  logic                        in_window;

  logic                        lvl_we, lvl_re;
  logic [SW-1:0]               lvl_addr;
  logic [plb_pkg::ENTRY_W-1:0] lvl_wdata, lvl_rdata;
  logic                        occ_we, occ_re;
  logic [WW-1:0]               occ_addr;
  logic [plb_pkg::WORD_W-1:0]  occ_wdata, occ_rdata;

  logic [SXW-1:0]              slot_ext;
  logic [WW-1:0]               slot_word;
  logic [plb_pkg::BIT_W-1:0]   slot_bit;

  logic [plb_pkg::QTY_W-1:0]   cur_tot, new_tot;
  logic [plb_pkg::CNT_W-1:0]   cur_cnt, new_cnt;
  logic [plb_pkg::QTY_W:0]     sum;
  logic [1:0]                  mod_status;
  logic                        mod_write, mod_occ_bit, need_search, better;

  logic                        scan_found;
  logic [plb_pkg::BIT_W-1:0]   scan_idx;
  logic                        scan_issue;
  logic                        out_free;

  assign off       = req.price - base_price;
  assign in_window = (req.price >= base_price) && (off < plb_pkg::PRICE_W'(LEVELS));

  assign slot_ext  = SXW'(slot);
  assign slot_word = WW'(slot_ext >> plb_pkg::BIT_W);
  assign slot_bit  = slot_ext[plb_pkg::BIT_W-1:0];

  assign cur_tot = lvl_rdata[plb_pkg::QTY_W-1:0];
  assign cur_cnt = lvl_rdata[plb_pkg::ENTRY_W-1:plb_pkg::QTY_W];
  assign sum     = {1'b0, cur_tot} + (plb_pkg::QTY_W + 1)'(item_qty);
  assign better  = (book_side == plb_pkg::SIDE_BID) ? (slot > best_slot) : (slot < best_slot);

  assign scan_issue = scan_n < NW'(WORDS);
  assign out_free   = !rsp.valid || rsp.ready;
  assign req.ready  = (state == S_IDLE);

  always_comb begin
    new_tot     = cur_tot;
    new_cnt     = cur_cnt;
    mod_status  = plb_pkg::ST_OK;
    mod_write   = 1'b0;
    mod_occ_bit = 1'b1;
    need_search = 1'b0;
    if (item_cmd != plb_pkg::CMD_NOP && !in_range) begin
      mod_status = plb_pkg::ST_RANGE;
    end else if (in_range) begin
      unique case (item_cmd)
        plb_pkg::CMD_ADD: begin
          mod_write = 1'b1;
          if (sum > (plb_pkg::QTY_W + 1)'(plb_pkg::QTY_MAX)) begin
            new_tot    = plb_pkg::QTY_MAX;
            mod_status = plb_pkg::ST_SAT;
          end else begin
            new_tot = sum[plb_pkg::QTY_W-1:0];
          end
          if (cur_cnt == plb_pkg::CNT_MAX) begin
            mod_status = plb_pkg::ST_SAT;
          end else begin
            new_cnt = cur_cnt + 1'b1;
          end
        end
        plb_pkg::CMD_REMOVE: begin
          if (cur_cnt == '0) begin
            mod_status = plb_pkg::ST_EMPTY;
          end else begin
            mod_write = 1'b1;
            if (plb_pkg::QTY_W'(item_qty) > cur_tot) begin
              new_tot    = '0;
              mod_status = plb_pkg::ST_SAT;
            end else begin
              new_tot = cur_tot - plb_pkg::QTY_W'(item_qty);
            end
            new_cnt = cur_cnt - 1'b1;
            if (new_cnt == '0) begin
              new_tot     = '0;
              mod_occ_bit = 1'b0;
              need_search = best_present && (best_slot == slot);
            end
          end
        end
        plb_pkg::CMD_CLEAR: begin
          mod_write   = 1'b1;
          new_tot     = '0;
          new_cnt     = '0;
          mod_occ_bit = 1'b0;
          need_search = best_present && (best_slot == slot);
        end
        plb_pkg::CMD_NOP: begin
          mod_write = 1'b0;
        end
        default: begin
          mod_write = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    lvl_we    = 1'b0;
    lvl_re    = 1'b0;
    lvl_addr  = slot;
    lvl_wdata = {new_cnt, new_tot};
    occ_we    = 1'b0;
    occ_re    = 1'b0;
    occ_addr  = slot_word;
    occ_wdata = occ_rdata;
    occ_wdata[slot_bit] = mod_occ_bit;
    unique case (state)
      S_CLEAR: begin
        lvl_we    = 1'b1;
        lvl_addr  = clr_cnt;
        lvl_wdata = '0;
        occ_we    = 32'(clr_cnt) < 32'(WORDS);
        occ_addr  = WW'(clr_cnt);
        occ_wdata = '0;
      end
      S_READ: begin
        lvl_re = 1'b1;
        occ_re = 1'b1;
      end
      S_MODIFY: begin
        lvl_we = mod_write;
        occ_we = mod_write;
      end
      S_SEARCH: begin
        occ_re   = scan_issue;
        occ_addr = scan_addr;
      end
      S_FETCH: begin
        lvl_re   = 1'b1;
        lvl_addr = best_slot;
      end
      S_IDLE, S_FETCHW, S_RESULT: begin
        lvl_re = 1'b0;
      end
      default: begin
        lvl_re = 1'b0;
      end
    endcase
  end

  plb_ram #(
    .WIDTH (plb_pkg::ENTRY_W),
    .DEPTH (LEVELS)
  ) u_level_ram (
    .clk   (clk),
    .we    (lvl_we),
    .re    (lvl_re),
    .addr  (lvl_addr),
    .wdata (lvl_wdata),
    .rdata (lvl_rdata)
  );

  plb_ram #(
    .WIDTH (plb_pkg::WORD_W),
    .DEPTH (WORDS)
  ) u_occ_ram (
    .clk   (clk),
    .we    (occ_we),
    .re    (occ_re),
    .addr  (occ_addr),
    .wdata (occ_wdata),
    .rdata (occ_rdata)
  );

  plb_prio u_prio (
    .word      (occ_rdata),
    .low_first (book_side == plb_pkg::SIDE_ASK),
    .found     (scan_found),
    .idx       (scan_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      base_price   <= '0;
      book_side    <= plb_pkg::SIDE_BID;
      best_slot    <= '0;
      best_present <= 1'b0;
      best_total   <= '0;
      scan_addr    <= '0;
      scan_n       <= '0;
      pend         <= 1'b0;
      rsp.valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == plb_pkg::REG_BASE_PRICE) begin
          base_price <= cfg_data;
        end else if (cfg_idx == plb_pkg::REG_BOOK_SIDE) begin
          book_side <= cfg_data[0];
        end
      end

      if (state == S_RESULT && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == SW'(LEVELS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            item_cmd <= plb_pkg::cmd_t'(req.cmd);
            item_qty <= req.qty;
            slot     <= SW'(off);
            in_range <= in_window;
            state    <= S_READ;
          end
        end
        S_READ: begin
          state <= S_MODIFY;
        end
        S_MODIFY: begin
          res_status <= mod_status;
          res_lq     <= in_range && item_cmd != plb_pkg::CMD_NOP ? new_tot : '0;
          res_lo     <= in_range && item_cmd != plb_pkg::CMD_NOP ? new_cnt : '0;
          state      <= need_search ? S_SEARCH : S_RESULT;
          scan_addr  <= (book_side == plb_pkg::SIDE_ASK) ? '0 : WW'(WORDS - 1);
          scan_n     <= '0;
          pend       <= 1'b0;
          if (in_range && mod_write) begin
            if (item_cmd == plb_pkg::CMD_ADD) begin
              if (!best_present || better) begin
                best_slot    <= slot;
                best_present <= 1'b1;
                best_total   <= new_tot;
              end else if (best_slot == slot) begin
                best_total <= new_tot;
              end
            end else if (best_present && best_slot == slot && !need_search) begin
              best_total <= new_tot;
            end
          end
        end
        S_SEARCH: begin
          if (pend && scan_found) begin
            best_slot <= SW'({pend_addr, scan_idx});
            state     <= S_FETCH;
          end else if (!scan_issue) begin
            best_present <= 1'b0;
            best_slot    <= '0;
            best_total   <= '0;
            state        <= S_RESULT;
          end else begin
            pend      <= 1'b1;
            pend_addr <= scan_addr;
            scan_n    <= scan_n + 1'b1;
            scan_addr <= (book_side == plb_pkg::SIDE_ASK) ? scan_addr + 1'b1 : scan_addr - 1'b1;
          end
        end
        S_FETCH: begin
          state <= S_FETCHW;
        end
        S_FETCHW: begin
          best_total <= cur_tot;
          state      <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            rsp.status       <= res_status;
            rsp.level_qty    <= res_lq;
            rsp.level_orders <= res_lo;
            rsp.best_valid   <= best_present;
            rsp.top_price    <= best_present ? base_price + plb_pkg::PRICE_W'(best_slot) : '0;
            rsp.best_qty     <= best_present ? best_total : '0;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PLB_ASSERT_NXT(a_accept_reads, clk, rst, req.valid && req.ready, state == S_READ,
                  "accepted item did not start a level read")
  `PLB_ASSERT_IMP(a_result_source, clk, rst, $rose(rsp.valid), $past(state == S_RESULT),
                  "result appeared outside the result step")
  `PLB_ASSERT_IMP(a_empty_best, clk, rst, !best_present,
                  (best_total == '0) && (best_slot == '0),
                  "empty book holds a stale best level")

endmodule

// File: sim/tb.sv
// Self-checking testbench for price_ladder_best_tracker: directed rows, random order flow,
// a burst of large orders on one level, and several window and side settings.
// Depends on plb_pkg, plb_req_if and plb_rsp_if from the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVELS = 1024;
  localparam int STALL_LIMIT = 6000;
  localparam logic [plb_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    plb_pkg::status_t                 status;
    logic [plb_pkg::QTY_W-1:0]        level_qty;
    logic [plb_pkg::CNT_W-1:0]        level_orders;
    logic                             best_valid;
    logic [plb_pkg::PRICE_W-1:0]      top_price;
    logic [plb_pkg::QTY_W-1:0]        best_qty;
  } ladder_out_t;

  typedef struct packed {
    logic        known;
    ladder_out_t res;
  } typed_row_t;

  typedef struct packed {
    plb_pkg::cmd_t cmd;
    logic [31:0]   price;
    logic [31:0]   qty;
    logic          known;
    ladder_out_t   res;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [plb_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [plb_pkg::CFG_DATA_W-1:0] cfg_data;

  plb_req_if req_ch();
  plb_rsp_if rsp_ch();

  price_ladder_best_tracker #(.LEVELS(LEVELS)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  logic [plb_pkg::QTY_W-1:0] lvl_total [LEVELS];
  logic [plb_pkg::CNT_W-1:0] lvl_count [LEVELS];
  logic                      lvl_occ [LEVELS];
  logic [9:0]                best_slot_m;
  logic                      best_here;
  logic [31:0]               book_base;
  logic                      book_ask;

  ladder_out_t expected_q [$];
  typed_row_t  typed_q [$];
  int fails;
  int req_idle_pct;
  int rsp_idle_pct;
  int quiet_cycles;

  dir_row_t bid_rows [15] = '{
    '{plb_pkg::CMD_REMOVE, 32'd5, 32'd1, 1'b1,
      '{plb_pkg::ST_EMPTY, 48'd0, 16'd0, 1'b0, 32'd0, 48'd0}},
    '{plb_pkg::CMD_ADD, 32'd1024, 32'd7, 1'b1,
      '{plb_pkg::ST_RANGE, 48'd0, 16'd0, 1'b0, 32'd0, 48'd0}},
    '{plb_pkg::CMD_ADD, 32'd0, 32'hFFFF_FFFF, 1'b1,
      '{plb_pkg::ST_OK, 48'hFFFF_FFFF, 16'd1, 1'b1, 32'd0, 48'hFFFF_FFFF}},
    '{plb_pkg::CMD_ADD, 32'd1023, 32'd1, 1'b1,
      '{plb_pkg::ST_OK, 48'd1, 16'd1, 1'b1, 32'd1023, 48'd1}},
    '{plb_pkg::CMD_CLEAR, 32'd1023, 32'd0, 1'b1,
      '{plb_pkg::ST_OK, 48'd0, 16'd0, 1'b1, 32'd0, 48'hFFFF_FFFF}},
    '{plb_pkg::CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{plb_pkg::ST_OK, 48'd0, 16'd0, 1'b1, 32'd0, 48'hFFFF_FFFF}},
    '{plb_pkg::CMD_REMOVE, 32'd0, 32'hFFFF_FFFF, 1'b1,
      '{plb_pkg::ST_OK, 48'd0, 16'd0, 1'b0, 32'd0, 48'd0}},
    '{plb_pkg::CMD_ADD, 32'd10, 32'd100, 1'b0, '0},
    '{plb_pkg::CMD_ADD, 32'd10, 32'd50, 1'b0, '0},
    '{plb_pkg::CMD_ADD, 32'd5, 32'd9, 1'b0, '0},
    '{plb_pkg::CMD_REMOVE, 32'd10, 32'd500, 1'b1,
      '{plb_pkg::ST_SAT, 48'd0, 16'd1, 1'b1, 32'd10, 48'd0}},
    '{plb_pkg::CMD_ADD, 32'd20, 32'd5, 1'b0, '0},
    '{plb_pkg::CMD_REMOVE, 32'd20, 32'd5, 1'b0, '0},
    '{plb_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'd1, 1'b1,
      '{plb_pkg::ST_RANGE, 48'd0, 16'd0, 1'b1, 32'd10, 48'd0}},
    '{plb_pkg::CMD_CLEAR, 32'd5, 32'd0, 1'b0, '0}
  };

  dir_row_t ask_rows [8] = '{
    '{plb_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'd3, 1'b1,
      '{plb_pkg::ST_OK, 48'd3, 16'd1, 1'b1, 32'hFFFF_FC0A, 48'd0}},
    '{plb_pkg::CMD_ADD, 32'hFFFF_FC00, 32'd2, 1'b1,
      '{plb_pkg::ST_OK, 48'd2, 16'd1, 1'b1, 32'hFFFF_FC00, 48'd2}},
    '{plb_pkg::CMD_REMOVE, 32'hFFFF_FC00, 32'd2, 1'b0, '0},
    '{plb_pkg::CMD_ADD, 32'd0, 32'd1, 1'b1,
      '{plb_pkg::ST_RANGE, 48'd0, 16'd0, 1'b1, 32'hFFFF_FC0A, 48'd0}},
    '{plb_pkg::CMD_CLEAR, 32'hFFFF_FC0A, 32'd0, 1'b0, '0},
    '{plb_pkg::CMD_NOP, 32'd0, 32'd0, 1'b0, '0},
    '{plb_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{plb_pkg::ST_SAT, 48'd0, 16'd0, 1'b0, 32'd0, 48'd0}},
    '{plb_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'd1, 1'b1,
      '{plb_pkg::ST_EMPTY, 48'd0, 16'd0, 1'b0, 32'd0, 48'd0}}
  };

  function automatic void rescan_best();
    best_here = 1'b0;
    best_slot_m = '0;
    for (int s = 0; s < LEVELS; s++) begin
      if (lvl_occ[s] && (!best_here || (book_ask ? s < best_slot_m : s > best_slot_m))) begin
        best_slot_m = s[9:0];
        best_here = 1'b1;
      end
    end
  endfunction

  function automatic ladder_out_t book_apply(plb_pkg::cmd_t c, logic [31:0] p,
                                             logic [31:0] q);
    ladder_out_t r;
    logic [31:0] off;
    logic in_win;
    logic [9:0] slot;
    logic [48:0] sum;
    r = '0;
    off = p - book_base;
    in_win = (p >= book_base) && (off < LEVELS);
    slot = off[9:0];
    if (c != plb_pkg::CMD_NOP && !in_win) begin
      r.status = plb_pkg::ST_RANGE;
    end else if (c == plb_pkg::CMD_ADD) begin
      sum = {1'b0, lvl_total[slot]} + {17'd0, q};
      if (sum > {1'b0, plb_pkg::QTY_MAX}) begin
        sum = {1'b0, plb_pkg::QTY_MAX};
        r.status = plb_pkg::ST_SAT;
      end
      lvl_total[slot] = sum[plb_pkg::QTY_W-1:0];
      if (lvl_count[slot] == plb_pkg::CNT_MAX) r.status = plb_pkg::ST_SAT;
      else lvl_count[slot] = lvl_count[slot] + 1'b1;
      lvl_occ[slot] = 1'b1;
      if (!best_here || (book_ask ? slot < best_slot_m : slot > best_slot_m)) begin
        best_slot_m = slot;
        best_here = 1'b1;
      end
    end else if (c == plb_pkg::CMD_REMOVE) begin
      if (lvl_count[slot] == 0) begin
        r.status = plb_pkg::ST_EMPTY;
      end else begin
        if ({16'd0, q} > lvl_total[slot]) begin
          lvl_total[slot] = '0;
          r.status = plb_pkg::ST_SAT;
        end else begin
          lvl_total[slot] = lvl_total[slot] - q;
        end
        lvl_count[slot] = lvl_count[slot] - 1'b1;
        if (lvl_count[slot] == 0) begin
          lvl_total[slot] = '0;
          lvl_occ[slot] = 1'b0;
          if (best_here && best_slot_m == slot) rescan_best();
        end
      end
    end else if (c == plb_pkg::CMD_CLEAR) begin
      lvl_total[slot] = '0;
      lvl_count[slot] = '0;
      lvl_occ[slot] = 1'b0;
      if (best_here && best_slot_m == slot) rescan_best();
    end
    if (c != plb_pkg::CMD_NOP && in_win) begin
      r.level_qty = lvl_total[slot];
      r.level_orders = lvl_count[slot];
    end
    if (best_here) begin
      r.best_valid = 1'b1;
      r.top_price = book_base + {22'd0, best_slot_m};
      r.best_qty = lvl_total[best_slot_m];
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  task automatic send_cmd(plb_pkg::cmd_t c, logic [31:0] p, logic [31:0] q, logic known,
                          ladder_out_t res);
    typed_q.insert(typed_q.size(), typed_row_t'({known, res}));
    while ($urandom_range(99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      req_ch.cmd <= 2'($urandom);
      req_ch.price <= $urandom;
      req_ch.qty <= $urandom;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= c;
    req_ch.price <= p;
    req_ch.qty <= q;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_book(logic [31:0] base, logic ask);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= plb_pkg::REG_BASE_PRICE;
    cfg_data <= base;
    @(posedge clk);
    cfg_idx <= plb_pkg::REG_BOOK_SIDE;
    cfg_data <= ($urandom & 32'hFFFF_FFFE) | {31'd0, ask};
    @(posedge clk);
    cfg_idx <= REG_SPARE;
    cfg_data <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int n);
    plb_pkg::cmd_t c;
    logic [31:0] p;
    logic [31:0] q;
    int sel;
    int s;
    repeat (n) begin
      sel = $urandom_range(99);
      c = (sel < 45) ? plb_pkg::CMD_ADD : (sel < 78) ? plb_pkg::CMD_REMOVE :
          (sel < 92) ? plb_pkg::CMD_CLEAR : plb_pkg::CMD_NOP;
      sel = $urandom_range(99);
      if (sel < 30) s = $urandom_range(LEVELS - 1);
      else if (sel < 55) s = $urandom_range(7);
      else if (sel < 75) s = LEVELS - 1 - $urandom_range(7);
      else if (sel < 90) s = 500 + $urandom_range(15);
      else s = -1;
      if (s >= 0) begin
        p = book_base + s;
      end else begin
        sel = $urandom_range(2);
        if (sel == 0) p = $urandom;
        else if (sel == 1) p = book_base - 1 - $urandom_range(3);
        else p = book_base + LEVELS + $urandom_range(3);
      end
      sel = $urandom_range(99);
      if (sel < 25) q = $urandom;
      else if (sel < 70) q = $urandom_range(15);
      else if (sel < 85) q = '1;
      else q = '0;
      send_cmd(c, p, q, 1'b0, '0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    ladder_out_t want;
    typed_row_t row;
    if (rst) begin
      book_base = '0;
      book_ask = 1'b0;
      best_slot_m = '0;
      best_here = 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        lvl_total[i] = '0;
        lvl_count[i] = '0;
        lvl_occ[i] = 1'b0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          plb_pkg::REG_BASE_PRICE: book_base = cfg_data;
          plb_pkg::REG_BOOK_SIDE: book_ask = cfg_data[0];
          default: ;
        endcase
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t ns: result item with none expected, status %0d", $time, rsp_ch.status);
          fails++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", want.status, rsp_ch.status);
          check_field("level_qty", want.level_qty, rsp_ch.level_qty);
          check_field("level_orders", want.level_orders, rsp_ch.level_orders);
          check_field("best_valid", want.best_valid, rsp_ch.best_valid);
          check_field("top_price", want.top_price, rsp_ch.top_price);
          check_field("best_qty", want.best_qty, rsp_ch.best_qty);
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        want = book_apply(plb_pkg::cmd_t'(req_ch.cmd), req_ch.price, req_ch.qty);
        row = typed_q.pop_front();
        if (row.known) want = row.res;
        expected_q.insert(expected_q.size(), want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int got;
    int hold;
    got = 0;
    hold = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got++;
        if (got == 150 || got == 900) hold = 500;
      end
      if (hold > 0) begin
        hold--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd = '0;
    req_ch.price = '0;
    req_ch.qty = '0;
    req_idle_pct = 38;
    rsp_idle_pct = 38;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (bid_rows[i])
      send_cmd(bid_rows[i].cmd, bid_rows[i].price, bid_rows[i].qty, bid_rows[i].known,
               bid_rows[i].res);
    set_book(32'hFFFF_FC00, plb_pkg::SIDE_ASK);
    foreach (ask_rows[i])
      send_cmd(ask_rows[i].cmd, ask_rows[i].price, ask_rows[i].qty, ask_rows[i].known,
               ask_rows[i].res);

    set_book(32'd0, plb_pkg::SIDE_BID);
    run_random(220);
    set_book(32'h7FFF_FE00, plb_pkg::SIDE_ASK);
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    run_random(220);
    set_book($urandom, plb_pkg::SIDE_BID);
    req_idle_pct = 38;
    rsp_idle_pct = 38;
    run_random(220);
    set_book(32'hFFFF_FFFF, plb_pkg::SIDE_ASK);
    run_random(120);
    set_book(32'hFFFF_FC00, plb_pkg::SIDE_BID);
    run_random(220);

    set_book(32'd0, plb_pkg::SIDE_BID);
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    repeat (70) send_cmd(plb_pkg::CMD_ADD, 32'd700, 32'hFFFF_FFFF, 1'b0, '0);
    send_cmd(plb_pkg::CMD_REMOVE, 32'd700, 32'd0, 1'b0, '0);
    send_cmd(plb_pkg::CMD_ADD, 32'd701, 32'd4, 1'b0, '0);
    send_cmd(plb_pkg::CMD_CLEAR, 32'd701, 32'd0, 1'b0, '0);
    send_cmd(plb_pkg::CMD_CLEAR, 32'd700, 32'd0, 1'b0, '0);

    drain();
    repeat (60) @(posedge clk);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
